>>> rtl/core/ball_balance_servo_follow_defines.svh
// ----------------------------------------------------------------------------
// Ball balance servo follower - assertion macros
// Concurrent assertion shorthands on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BALL_BALANCE_SERVO_FOLLOW_DEFINES_SVH
`define BALL_BALANCE_SERVO_FOLLOW_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define BBSF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbsf assertion failed");

// antecedent implies consequent in the next cycle
`define BBSF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbsf assertion failed");

`endif

>>> rtl/core/bbsf_pkg.sv
// ----------------------------------------------------------------------------
// bbsf_pkg
// Types, limits and register indexes of the ball balance servo follower.
// ----------------------------------------------------------------------------
package bbsf_pkg;

    localparam int PULSE_MIN  = 500;
    localparam int PULSE_MAX  = 2500;
    localparam int MISS_LIMIT = 12;
    localparam int HIT_LIMIT  = 2;

    localparam logic [11:0] PULSE_MIN_P  = 12'(PULSE_MIN);
    localparam logic [11:0] PULSE_MAX_P  = 12'(PULSE_MAX);
    localparam logic [3:0]  MISS_LIMIT_P = 4'(MISS_LIMIT);
    localparam logic [1:0]  HIT_LIMIT_P  = 2'(HIT_LIMIT);

    // register reset values
    localparam logic [11:0] CENTER_RST = 12'd1500;
    localparam logic [11:0] LEFT_RST   = 12'd1000;
    localparam logic [11:0] RIGHT_RST  = 12'd2000;
    localparam logic [14:0] DEAD_RST   = 15'd5243;
    localparam logic [15:0] SWING_RST  = 16'd19661;
    localparam logic [7:0]  NEAR_RST   = 8'd12;
    localparam logic [7:0]  FAR_RST    = 8'd80;

    // configuration register indexes
    localparam logic [2:0] CFG_CENTER = 3'd0;
    localparam logic [2:0] CFG_LEFT   = 3'd1;
    localparam logic [2:0] CFG_RIGHT  = 3'd2;
    localparam logic [2:0] CFG_INVERT = 3'd3;
    localparam logic [2:0] CFG_DEAD   = 3'd4;
    localparam logic [2:0] CFG_SWING  = 3'd5;
    localparam logic [2:0] CFG_NEAR   = 3'd6;
    localparam logic [2:0] CFG_FAR    = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // serial divider: 17 quotient bits
    localparam int          DIV_STEPS = 17;
    localparam logic [4:0]  DIV_LAST  = 5'(DIV_STEPS - 1);

    typedef struct packed {
        logic        active;
        logic        report_ok;
        logic [31:0] frame_gen;
        logic        ball_seen;
        logic [11:0] box_left;
        logic [11:0] box_width;
        logic [11:0] frame_width;
    } report_t;

    typedef struct packed {
        logic [11:0] pulse_out;
        logic        lost_mode;
        logic [11:0] target_out;
    } servo_t;

    function automatic logic [11:0] clamp_pose(logic [11:0] v);
        logic [11:0] r;
        r = v;
        if (v < PULSE_MIN_P)
            r = PULSE_MIN_P;
        else if (v > PULSE_MAX_P)
            r = PULSE_MAX_P;
        return r;
    endfunction

endpackage

>>> rtl/core/bbsf_channels.sv
// ----------------------------------------------------------------------------
// bbsf channels
// Valid/ready channels for detection reports and servo commands.
// ----------------------------------------------------------------------------
interface bbsf_report_if;
    import bbsf_pkg::*;

    logic    valid;
    logic    ready;
    report_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bbsf_servo_if;
    import bbsf_pkg::*;

    logic   valid;
    logic   ready;
    servo_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/ball_balance_servo_follow.sv
// ----------------------------------------------------------------------------
// ball_balance_servo_follow
// Servo follower: ball position from a detection report, deadzone, weighted
// swing, slew limit and lost/found tracking.
// An inactive report goes straight to the output; the position and, outside the
// deadzone, the swing fraction each take a 17-step bit-serial divide, and lost
// entry or found exit adds an extra slew step.
// One report in flight; the next transaction is taken in the cycle after the
// result moves into the output register, which may still be waiting.
// Reset: registers to their reset values, pulse and target to 1500, counters
// and lost mode cleared; no clearing pass.
// ----------------------------------------------------------------------------
module ball_balance_servo_follow (
    input  logic                             clk,
    input  logic                             rst_n,
    bbsf_report_if.sink                      report,
    bbsf_servo_if.source                     servo,
    input  logic                             cfg_we,
    input  logic [bbsf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bbsf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bbsf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECIDE = 4'd1;
    localparam logic [3:0] S_DIV    = 4'd2;
    localparam logic [3:0] S_POS    = 4'd3;
    localparam logic [3:0] S_MUL1   = 4'd4;
    localparam logic [3:0] S_MUL2   = 4'd5;
    localparam logic [3:0] S_ROUND  = 4'd6;
    localparam logic [3:0] S_SLEW   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    localparam logic signed [30:0] V_LO = 31'(PULSE_MIN * 65536);
    localparam logic signed [30:0] V_HI = 31'(PULSE_MAX * 65536);

    // configuration
    logic [11:0] center_reg, left_reg, right_reg;
    logic        invert_reg;
    logic [14:0] dead_reg;
    logic [15:0] swing_reg;
    logic [7:0]  near_reg, far_reg;

    // control and tracking state
    logic [3:0]  state_reg, state_next;
    logic [11:0] applied_reg, applied_next;
    logic [11:0] target_reg, target_next;
    logic [3:0]  miss_reg, miss_next;
    logic [1:0]  hit_reg, hit_next;
    logic [31:0] last_gen_reg, last_gen_next;
    logic        lost_reg, lost_next;
    logic        far_pend_reg, far_pend_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        frac_mode_reg, frac_mode_next;
    logic        out_valid_reg, out_valid_next;

    // datapath
    report_t        in_reg, in_next;
    logic [16:0]    rem_reg, rem_next;
    logic [15:0]    dvs_reg, dvs_next;
    logic [16:0]    quo_reg, quo_next;
    logic           side_reg, side_next;
    logic [15:0]    w_reg, w_next;
    logic signed [29:0] prod_reg, prod_next;
    servo_t         out_data_reg, out_data_next;

    // combinational helpers
    logic [11:0] ctr;
    logic [12:0] cx, fw13;
    logic [11:0] cx_cl;
    logic [1:0]  hit_inc;
    logic [3:0]  miss_inc;
    logic        div_ge;
    logic [16:0] div_diff, div_rem;
    logic [15:0] pos, aerr, db16;
    logic [32:0] mul1;
    logic [11:0] ext, ext_raw;
    logic signed [12:0] ext_diff;
    logic signed [29:0] mul2;
    logic signed [30:0] v_sum, v_cl, v_rnd;

    function automatic logic [11:0] slew_to(logic [11:0] cur, logic [11:0] tgt,
                                            logic [7:0] step);
        logic signed [12:0] d;
        logic signed [12:0] s;
        d = $signed({1'b0, tgt}) - $signed({1'b0, cur});
        s = $signed({5'b0, step});
        if (d > s)
            d = s;
        else if (d < -s)
            d = -s;
        return cur + d[11:0];
    endfunction

    assign ctr          = clamp_pose(center_reg);
    assign report.ready = (state_reg == S_IDLE);
    assign servo.valid  = out_valid_reg;
    assign servo.data   = out_data_reg;

    // ball center x, kept inside the frame
    assign cx    = {1'b0, in_reg.box_left} + {2'b0, in_reg.box_width[11:1]};
    assign fw13  = {1'b0, in_reg.frame_width};
    assign cx_cl = (cx >= fw13) ? 12'(fw13 - 13'd1) : cx[11:0];

    assign hit_inc  = (hit_reg == 2'd3) ? 2'd3 : hit_reg + 2'd1;
    assign miss_inc = (miss_reg == 4'd15) ? 4'd15 : miss_reg + 4'd1;

    // restoring divide, one quotient bit per cycle
    assign div_ge   = (rem_reg >= {1'b0, dvs_reg});
    assign div_diff = rem_reg - {1'b0, dvs_reg};
    assign div_rem  = div_ge ? div_diff : rem_reg;

    assign pos  = quo_reg[15:0];
    assign aerr = pos[15] ? {1'b0, pos[14:0]} : 16'd32768 - pos;
    assign db16 = {1'b0, dead_reg};

    assign mul1 = 33'(quo_reg) * 33'(swing_reg);

    assign ext_raw  = side_reg ? (invert_reg ? left_reg : right_reg)
                               : (invert_reg ? right_reg : left_reg);
    assign ext      = clamp_pose(ext_raw);
    assign ext_diff = $signed({1'b0, ext}) - $signed({1'b0, ctr});
    assign mul2     = $signed({1'b0, w_reg}) * ext_diff;

    assign v_sum = $signed({3'b0, ctr, 16'b0}) + {prod_reg[29], prod_reg};
    assign v_cl  = (v_sum < V_LO) ? V_LO : ((v_sum > V_HI) ? V_HI : v_sum);
    assign v_rnd = v_cl + 31'sd32768;

    always_comb
    begin
        state_next     = state_reg;
        applied_next   = applied_reg;
        target_next    = target_reg;
        miss_next      = miss_reg;
        hit_next       = hit_reg;
        last_gen_next  = last_gen_reg;
        lost_next      = lost_reg;
        far_pend_next  = far_pend_reg;
        cnt_next       = cnt_reg;
        frac_mode_next = frac_mode_reg;
        out_valid_next = out_valid_reg;
        in_next        = in_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        quo_next       = quo_reg;
        side_next      = side_reg;
        w_next         = w_reg;
        prod_next      = prod_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && servo.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (report.valid)
                begin
                    in_next    = report.data;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_SLEW;
                if (!in_reg.active)
                    state_next = S_OUT;
                else if (in_reg.report_ok && in_reg.frame_gen != last_gen_reg)
                begin
                    last_gen_next = in_reg.frame_gen;
                    if (in_reg.ball_seen && in_reg.frame_width != 12'd0)
                    begin
                        miss_next = 4'd0;
                        hit_next  = hit_inc;
                        if (lost_reg)
                        begin
                            if (hit_inc >= HIT_LIMIT_P)
                            begin
                                lost_next     = 1'b0;
                                target_next   = ctr;
                                far_pend_next = 1'b1;
                            end
                        end
                        else
                        begin
                            // pos = (2cx+1) * 2^16 / (2fw)
                            rem_next       = {4'b0, cx_cl, 1'b1};
                            dvs_next       = {3'b0, in_reg.frame_width, 1'b0};
                            quo_next       = 17'd0;
                            cnt_next       = 5'd0;
                            frac_mode_next = 1'b0;
                            state_next     = S_DIV;
                        end
                    end
                    else
                    begin
                        hit_next  = 2'd0;
                        miss_next = miss_inc;
                        if (miss_inc >= MISS_LIMIT_P && !lost_reg)
                        begin
                            lost_next     = 1'b1;
                            target_next   = ctr;
                            far_pend_next = 1'b1;
                        end
                    end
                end
            end
            S_DIV:
            begin
                quo_next = {quo_reg[15:0], div_ge};
                rem_next = {div_rem[15:0], 1'b0};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == DIV_LAST)
                    state_next = frac_mode_reg ? S_MUL1 : S_POS;
            end
            S_POS:
            begin
                if (aerr <= db16)
                begin
                    target_next = ctr;
                    state_next  = S_SLEW;
                end
                else
                begin
                    // frac = (|err| - db) * 2^16 / (0.5 - db), at most 1.0
                    rem_next       = {1'b0, aerr - db16};
                    dvs_next       = 16'd32768 - db16;
                    side_next      = !pos[15];
                    quo_next       = 17'd0;
                    cnt_next       = 5'd0;
                    frac_mode_next = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_MUL1:
            begin
                w_next     = mul1[31:16];
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                prod_next  = mul2;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                target_next = v_rnd[27:16];
                state_next  = S_SLEW;
            end
            S_SLEW:
            begin
                if (far_pend_reg)
                begin
                    // lost entry / found exit: extra far step toward center
                    applied_next  = slew_to(applied_reg, target_reg, far_reg);
                    far_pend_next = 1'b0;
                end
                else
                begin
                    if (lost_reg)
                    begin
                        target_next  = ctr;
                        applied_next = slew_to(applied_reg, ctr, far_reg);
                    end
                    else
                        applied_next = slew_to(applied_reg, target_reg, near_reg);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || servo.ready)
                begin
                    out_data_next.pulse_out  = applied_reg;
                    out_data_next.lost_mode  = lost_reg;
                    out_data_next.target_out = target_reg;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            applied_reg   <= CENTER_RST;
            target_reg    <= CENTER_RST;
            miss_reg      <= 4'd0;
            hit_reg       <= 2'd0;
            last_gen_reg  <= 32'd0;
            lost_reg      <= 1'b0;
            far_pend_reg  <= 1'b0;
            cnt_reg       <= 5'd0;
            frac_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            applied_reg   <= applied_next;
            target_reg    <= target_next;
            miss_reg      <= miss_next;
            hit_reg       <= hit_next;
            last_gen_reg  <= last_gen_next;
            lost_reg      <= lost_next;
            far_pend_reg  <= far_pend_next;
            cnt_reg       <= cnt_next;
            frac_mode_reg <= frac_mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        quo_reg      <= quo_next;
        side_reg     <= side_next;
        w_reg        <= w_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= CENTER_RST;
            left_reg   <= LEFT_RST;
            right_reg  <= RIGHT_RST;
            invert_reg <= 1'b0;
            dead_reg   <= DEAD_RST;
            swing_reg  <= SWING_RST;
            near_reg   <= NEAR_RST;
            far_reg    <= FAR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER: center_reg <= cfg_data[11:0];
                CFG_LEFT:   left_reg   <= cfg_data[11:0];
                CFG_RIGHT:  right_reg  <= cfg_data[11:0];
                CFG_INVERT: invert_reg <= cfg_data[0];
                CFG_DEAD:   dead_reg   <= cfg_data[14:0];
                CFG_SWING:  swing_reg  <= cfg_data[15:0];
                CFG_NEAR:   near_reg   <= cfg_data[7:0];
                CFG_FAR:    far_reg    <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

endmodule

>>> rtl/core/bbsf_checker.sv
// ----------------------------------------------------------------------------
// bbsf_checker
// Port-level checks of the servo follower, bound to the top level.
// ----------------------------------------------------------------------------
`include "ball_balance_servo_follow_defines.svh"

module bbsf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] pulse_out,
    input logic        lost_mode,
    input logic [11:0] target_out
);
    import bbsf_pkg::*;

    // one report in flight at a time
    `BBSF_ASSERT_NEXT(a_single_item, in_valid && in_ready, !in_ready)

    `BBSF_ASSERT_SAME(a_pulse_range, out_valid,
        pulse_out >= PULSE_MIN_P && pulse_out <= PULSE_MAX_P)

    `BBSF_ASSERT_SAME(a_target_range, out_valid,
        target_out >= PULSE_MIN_P && target_out <= PULSE_MAX_P)

    `BBSF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(pulse_out) && $stable(lost_mode) && $stable(target_out))

endmodule

bind ball_balance_servo_follow bbsf_checker u_bbsf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (report.valid),
    .in_ready   (report.ready),
    .out_valid  (servo.valid),
    .out_ready  (servo.ready),
    .pulse_out  (servo.data.pulse_out),
    .lost_mode  (servo.data.lost_mode),
    .target_out (servo.data.target_out)
);
